/* rtl/tces_pkg.sv */
`default_nettype none

package tces_pkg;

  localparam int BARREL_CELL_THETA_DEF = 11;
  localparam int BARREL_CELL_PHI_DEF   = 30;
  localparam int ENDCAP_CELL_PHI_DEF   = 32;
  localparam int SUM_WIDTH_DEF         = 40;

  localparam int CELL_ENERGY_W = 40;
  // adc (12 bits) times gain (16 bits), shifted left by at most 6.
  localparam int PROD_W        = 34;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PART_EAST   = 2'd0,
    PART_BARREL = 2'd1,
    PART_WEST   = 2'd2,
    PART_NONE   = 2'd3
  } part_t;

  localparam logic [1:0] RANGE_X2  = 2'd0;
  localparam logic [1:0] RANGE_X16 = 2'd1;

  typedef struct packed {
    action_t      action;
    part_t        part;
    logic [5:0]   crystal_ring;
    logic [6:0]   crystal_phi;
    logic [11:0]  crystal_adc;
    logic [1:0]   measure_range;
    logic [15:0]  crystal_gain;
    logic [3:0]   read_theta;
    logic [4:0]   read_phi;
  } item_t;

  typedef struct packed {
    logic [1:0]               cell_part;
    logic [3:0]               cell_theta;
    logic [4:0]               cell_phi;
    logic [CELL_ENERGY_W-1:0] cell_energy;
    logic                     saturated;
    logic                     bad_address;
  } result_t;

  // Cell location before masking; the endcap phi cell of an add can reach 63.
  typedef struct packed {
    logic       bad;
    logic [3:0] theta;
    logic [6:0] phi;
  } cell_loc_t;

endpackage

`default_nettype wire

/* rtl/tces_ram.sv */
`default_nettype none

module tces_ram import tces_pkg::*; #(
  parameter int WIDTH = SUM_WIDTH_DEF,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/tces_cell_map.sv */
`default_nettype none

module tces_cell_map import tces_pkg::*; #(
  parameter int BARREL_CELL_THETA = BARREL_CELL_THETA_DEF,
  parameter int BARREL_CELL_PHI   = BARREL_CELL_PHI_DEF,
  parameter int ENDCAP_CELL_PHI   = ENDCAP_CELL_PHI_DEF,
  parameter int AW                = 9
) (
  input  wire item_t       item,
  output cell_loc_t        loc,
  output logic    [AW-1:0] addr
);

  localparam int BARREL_CELLS = BARREL_CELL_THETA * BARREL_CELL_PHI;

  logic [13:0] div3_prod;
  logic [14:0] div5_prod;
  logic [6:0]  phi_div3;
  logic [4:0]  phi_div5;
  logic [6:0]  phi_mod5;
  logic [6:0]  endcap_phi;

  logic        loc_bad;
  logic [3:0]  loc_theta;
  logic [6:0]  loc_phi;

  // Reciprocal multiplies; exact for every 7-bit phi.
  assign div3_prod = 14'(item.crystal_phi) * 14'd43;
  assign div5_prod = 15'(item.crystal_phi) * 15'd205;
  assign phi_div3  = 7'(div3_prod >> 7);
  assign phi_div5  = 5'(div5_prod >> 10);
  assign phi_mod5  = item.crystal_phi - 7'(phi_div5) * 7'd5;

  always_comb begin
    if (item.crystal_ring < 6'd2) begin
      endcap_phi = item.crystal_phi >> 1;
    end else if (item.crystal_ring == 6'd2) begin
      endcap_phi = 7'({phi_div5, 1'b0}) + 7'(phi_mod5 > 7'd1);
    end else if (item.crystal_ring == 6'd3) begin
      endcap_phi = 7'({phi_div5, 1'b0}) + 7'(phi_mod5 > 7'd2);
    end else begin
      endcap_phi = phi_div3;
    end
  end

  always_comb begin
    loc_theta = '0;
    loc_phi   = '0;
    if (item.action == ACT_ADD) begin
      if (item.part == PART_BARREL) begin
        loc_theta = item.crystal_ring[5:2];
        loc_phi   = {2'b00, item.crystal_phi[6:2]};
      end else if (item.part != PART_NONE) begin
        loc_phi   = endcap_phi;
      end
    end else begin
      loc_theta = item.read_theta;
      loc_phi   = {2'b00, item.read_phi};
    end
  end

  always_comb begin
    loc_bad = 1'b0;
    addr    = '0;
    unique case (item.part) inside
      PART_BARREL: begin
        if (32'(loc_theta) >= BARREL_CELL_THETA || 32'(loc_phi) >= BARREL_CELL_PHI) begin
          loc_bad = 1'b1;
        end else begin
          addr = AW'(32'(loc_theta) * BARREL_CELL_PHI + 32'(loc_phi));
        end
      end
      PART_EAST, PART_WEST: begin
        if (loc_theta != 4'd0 || 32'(loc_phi) >= ENDCAP_CELL_PHI) begin
          loc_bad = 1'b1;
        end else if (item.part == PART_EAST) begin
          addr = AW'(BARREL_CELLS + 32'(loc_phi));
        end else begin
          addr = AW'(BARREL_CELLS + ENDCAP_CELL_PHI + 32'(loc_phi));
        end
      end
      default: begin
        loc_bad = 1'b1;
      end
    endcase
  end

  assign loc = {loc_bad, loc_theta, loc_phi};

endmodule

`default_nettype wire

/* rtl/trigger_cell_energy_summer.sv */
// An accepted command passes the input, stage and result registers before its result
// shows with done high; add, read and clear each give exactly one result.
// Throughput: one add or read per cycle while busy is low; the cell RAM has one read
// port and one write port; the previous write is forwarded when the same cell recurs.
// A clear, and reset, hold busy high until all cells are zeroed (394 at the default size);
// the sweep waits while an earlier add is still writing; results cannot be stalled.
`default_nettype none

module trigger_cell_energy_summer import tces_pkg::*; #(
  parameter int BARREL_CELL_THETA = BARREL_CELL_THETA_DEF,
  parameter int BARREL_CELL_PHI   = BARREL_CELL_PHI_DEF,
  parameter int ENDCAP_CELL_PHI   = ENDCAP_CELL_PHI_DEF,
  parameter int SUM_WIDTH         = SUM_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  output logic       busy,
  input  wire item_t item,
  output logic       done,
  output result_t    result
);

  localparam int DEPTH = BARREL_CELL_THETA * BARREL_CELL_PHI + 2 * ENDCAP_CELL_PHI;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic accept;

  // Input register.
  logic  s0_valid;
  item_t s0_item;

  // Mapping and product stage.
  cell_loc_t           s0_loc;
  logic [AW-1:0]       s0_addr;
  logic [27:0]         s0_raw_prod;
  logic [PROD_W-1:0]   s0_prod;

  logic                s1_valid;
  action_t             s1_action;
  part_t               s1_part;
  cell_loc_t           s1_loc;
  logic [AW-1:0]       s1_addr;
  logic [PROD_W-1:0]   s1_prod;

  // Update stage.
  logic [SUM_WIDTH-1:0] ram_rdata;
  logic [SUM_WIDTH-1:0] old_sum;
  logic [SUM_WIDTH:0]   sum_wide;
  logic [SUM_WIDTH-1:0] new_sum;
  logic                 s1_we;
  result_t              result_next;

  // Last write, for a read issued in the same cycle as that write.
  logic                 last_we;
  logic [AW-1:0]        last_addr;
  logic [SUM_WIDTH-1:0] last_wdata;

  // Clearing sweep.
  logic          sweep_active;
  logic [AW-1:0] sweep_addr;
  logic          sweep_we;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [SUM_WIDTH-1:0] ram_wdata;

  assign busy   = sweep_active;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= accept;
    end
    if (accept) begin
      s0_item <= item;
    end
  end

  tces_cell_map #(
    .BARREL_CELL_THETA (BARREL_CELL_THETA),
    .BARREL_CELL_PHI   (BARREL_CELL_PHI),
    .ENDCAP_CELL_PHI   (ENDCAP_CELL_PHI),
    .AW                (AW)
  ) u_cell_map (
    .item (s0_item),
    .loc  (s0_loc),
    .addr (s0_addr)
  );

  assign s0_raw_prod = 28'(s0_item.crystal_adc) * 28'(s0_item.crystal_gain);

  always_comb begin
    case (s0_item.measure_range)
      RANGE_X2:  s0_prod = PROD_W'(s0_raw_prod) << 1;
      RANGE_X16: s0_prod = PROD_W'(s0_raw_prod) << 4;
      default:   s0_prod = PROD_W'(s0_raw_prod) << 6;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
    s1_action <= s0_item.action;
    s1_part   <= s0_item.part;
    s1_loc    <= s0_loc;
    s1_addr   <= s0_addr;
    s1_prod   <= s0_prod;
  end

  tces_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (s0_addr),
    .rdata (ram_rdata)
  );

  assign old_sum  = (last_we && last_addr == s1_addr) ? last_wdata : ram_rdata;
  assign sum_wide = {1'b0, old_sum} + (SUM_WIDTH + 1)'(s1_prod);

  always_comb begin
    if (s1_action == ACT_ADD) begin
      new_sum = sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
    end else begin
      new_sum = old_sum;
    end
  end

  assign s1_we = s1_valid && s1_action == ACT_ADD && !s1_loc.bad;

  always_comb begin
    result_next = '0;
    unique case (s1_action) inside
      ACT_ADD, ACT_READ: begin
        result_next.cell_part   = s1_part;
        result_next.cell_theta  = s1_loc.theta;
        result_next.cell_phi    = s1_loc.phi[4:0];
        result_next.bad_address = s1_loc.bad;
        if (!s1_loc.bad) begin
          result_next.cell_energy = CELL_ENERGY_W'(new_sum);
          result_next.saturated   = (new_sum == '1);
        end
      end
      ACT_NONE: begin
        result_next.bad_address = 1'b1;
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    result <= result_next;
  end

  // The sweep yields the write port to an add that was accepted before the clear.
  assign sweep_we  = sweep_active && !s1_we;
  assign ram_we    = s1_we || sweep_we;
  assign ram_waddr = s1_we ? s1_addr : sweep_addr;
  assign ram_wdata = s1_we ? new_sum : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_active <= 1'b1;
      sweep_addr   <= '0;
      last_we      <= 1'b0;
    end else begin
      last_we <= s1_we;
      if (accept && item.action == ACT_CLEAR) begin
        sweep_active <= 1'b1;
        sweep_addr   <= '0;
      end else if (sweep_we) begin
        if (sweep_addr == AW'(DEPTH - 1)) begin
          sweep_active <= 1'b0;
        end
        sweep_addr <= sweep_addr + AW'(1);
      end
    end
    last_addr  <= s1_addr;
    last_wdata <= new_sum;
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("accepted command gave no result three cycles later");

  a_result_has_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result without an accepted command");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && item.action == ACT_CLEAR) |=> busy)
    else $error("clear did not start the clearing sweep");

  a_bad_no_energy: assert property (@(posedge clk) disable iff (rst)
    (done && result.bad_address) |-> (result.cell_energy == '0 && !result.saturated))
    else $error("bad address result carries energy");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    s1_we |-> !sweep_we)
    else $error("sweep and add wrote the cell RAM together");

endmodule

`default_nettype wire
